@@ hw/rtl/spi_eeprom_device_model_defines.svh @@
// Assertion macros shared by the SPI EEPROM device model RTL.
// Expects signals clk and rst_n in the including scope.
`ifndef SPI_EEPROM_DEVICE_MODEL_DEFINES_SVH
`define SPI_EEPROM_DEVICE_MODEL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SEDM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sedm assertion failed");

// Next-cycle implication, checked out of reset.
`define SEDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sedm assertion failed");

`endif

@@ hw/rtl/sedm_pkg.sv @@
// Package for the SPI EEPROM device model: sizes, instruction codes,
// phase type and the memory request struct. No dependencies.
package sedm_pkg;

  localparam int ADDR_W     = 9;
  localparam int MEM_BYTES  = 1 << ADDR_W;
  localparam int PAGE_W     = 4;
  localparam int PAGE_BYTES = 1 << PAGE_W;

  localparam logic [2:0] INS_WRITE = 3'b010;
  localparam logic [2:0] INS_READ  = 3'b011;
  localparam logic [2:0] INS_WRDI  = 3'b100;
  localparam logic [2:0] INS_RDSR  = 3'b101;
  localparam logic [2:0] INS_WREN  = 3'b110;
  localparam logic [2:0] INS_NONE  = 3'b000;

  localparam logic [7:0] STATUS_WEL = 8'h02;
  localparam logic [7:0] ERASED     = 8'hFF;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_ADDR   = 2'd1,
    PH_DATA   = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/sedm_mem.sv @@
// Cell array of the SPI EEPROM device model with erase pass after reset
// and a prefetched read port. Depends on sedm_pkg.
module sedm_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  sedm_pkg::mem_req_t req,
  output logic [7:0]         rd_data,
  output logic               clr_busy
);

  logic [7:0]                  cells_r [sedm_pkg::MEM_BYTES];
  logic [7:0]                  rd_data_r;
  logic                        clr_busy_r;
  logic [sedm_pkg::ADDR_W-1:0] clr_addr_r;
  logic                        wr_en;
  logic [sedm_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                  wr_data;

  always_comb begin
    wr_en   = clr_busy_r | req.we;
    wr_addr = clr_busy_r ? clr_addr_r : req.waddr;
    wr_data = clr_busy_r ? sedm_pkg::ERASED : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + sedm_pkg::ADDR_W'(1);
      if (clr_addr_r == {sedm_pkg::ADDR_W{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == req.raddr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= cells_r[req.raddr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ hw/rtl/sedm_ctrl.sv @@
// Transaction decoder of the SPI EEPROM device model: phase, command,
// pointer, write-enable latch. Depends on sedm_pkg and the defines header.
`include "spi_eeprom_device_model_defines.svh"

module sedm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               op,
  input  logic [7:0]         mosi,
  input  logic [7:0]         rd_data,
  output logic [7:0]         miso,
  output sedm_pkg::mem_req_t mem_req
);

  sedm_pkg::phase_t            phase_r, phase_nxt;
  logic [2:0]                  cmd_r, cmd_nxt;
  logic [sedm_pkg::ADDR_W-1:0] pointer_r, pointer_nxt;
  logic                        latch_r, latch_nxt;
  logic                        wrote_r, wrote_nxt;
  logic                        a8_r, a8_nxt;
  logic [8:0]                  addr_full;

  assign addr_full = {a8_r, mosi};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sedm_pkg::PH_OPCODE;
      cmd_r     <= sedm_pkg::INS_NONE;
      pointer_r <= '0;
      latch_r   <= 1'b0;
      wrote_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      pointer_r <= pointer_nxt;
      latch_r   <= latch_nxt;
      wrote_r   <= wrote_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a8_r <= a8_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    pointer_nxt   = pointer_r;
    latch_nxt     = latch_r;
    wrote_nxt     = wrote_r;
    a8_nxt        = a8_r;
    miso          = 8'h00;
    mem_req.we    = 1'b0;
    mem_req.waddr = pointer_r;
    mem_req.wdata = mosi;
    if (fire) begin
      if (op) begin
        if (wrote_r) begin
          latch_nxt = 1'b0;
          wrote_nxt = 1'b0;
        end
        phase_nxt = sedm_pkg::PH_OPCODE;
        cmd_nxt   = sedm_pkg::INS_NONE;
      end else begin
        case (phase_r)
          sedm_pkg::PH_OPCODE: begin
            cmd_nxt   = sedm_pkg::INS_NONE;
            phase_nxt = sedm_pkg::PH_IGNORE;
            if (mosi[7:4] == 4'h0) begin
              case (mosi[2:0])
                sedm_pkg::INS_READ: begin
                  cmd_nxt   = sedm_pkg::INS_READ;
                  a8_nxt    = mosi[3];
                  phase_nxt = sedm_pkg::PH_ADDR;
                end
                sedm_pkg::INS_WRITE: begin
                  if (latch_r) begin
                    cmd_nxt   = sedm_pkg::INS_WRITE;
                    a8_nxt    = mosi[3];
                    phase_nxt = sedm_pkg::PH_ADDR;
                  end
                end
                sedm_pkg::INS_WREN: begin
                  latch_nxt = 1'b1;
                  cmd_nxt   = sedm_pkg::INS_WREN;
                end
                sedm_pkg::INS_WRDI: begin
                  latch_nxt = 1'b0;
                  cmd_nxt   = sedm_pkg::INS_WRDI;
                end
                sedm_pkg::INS_RDSR: begin
                  cmd_nxt   = sedm_pkg::INS_RDSR;
                  phase_nxt = sedm_pkg::PH_DATA;
                end
                default: begin
                end
              endcase
            end
          end
          sedm_pkg::PH_ADDR: begin
            pointer_nxt = addr_full[sedm_pkg::ADDR_W-1:0];
            phase_nxt   = sedm_pkg::PH_DATA;
          end
          sedm_pkg::PH_DATA: begin
            case (cmd_r)
              sedm_pkg::INS_READ: begin
                miso        = rd_data;
                pointer_nxt = pointer_r + sedm_pkg::ADDR_W'(1);
              end
              sedm_pkg::INS_WRITE: begin
                mem_req.we  = 1'b1;
                wrote_nxt   = 1'b1;
                pointer_nxt = {pointer_r[sedm_pkg::ADDR_W-1:sedm_pkg::PAGE_W],
                               pointer_r[sedm_pkg::PAGE_W-1:0] + sedm_pkg::PAGE_W'(1)};
              end
              sedm_pkg::INS_RDSR: begin
                miso = latch_r ? sedm_pkg::STATUS_WEL : 8'h00;
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end
    mem_req.raddr = pointer_nxt;
  end

  `SEDM_ASSERT_IMPL(a_write_needs_latch, mem_req.we, latch_r && (cmd_r == sedm_pkg::INS_WRITE))
  `SEDM_ASSERT_IMPL(a_wrote_implies_latch, wrote_r, latch_r)
  `SEDM_ASSERT_NEXT(a_release_to_opcode, fire && op,
                    (phase_r == sedm_pkg::PH_OPCODE) && (cmd_r == sedm_pkg::INS_NONE))

endmodule

@@ hw/rtl/spi_eeprom_device_model.sv @@
// SPI EEPROM device model: slave side of a 512-byte serial EEPROM.
// Channels:
//   in_*  : one transaction per SPI byte exchanged; in_tuser = 1 marks the
//           chip-select release that ends an SPI transaction (in_tdata ignored).
//   out_* : exactly one transaction per input, out_tdata = byte shifted out
//           (zero when the device drives nothing).
// Flow: an accepted input is captured in an input register, decoded when it
// fires and its result is registered onto out_*.
// Throughput: one input per cycle while out_* is not stalled; the cell array
// prefetches the byte at the current pointer so a READ byte does not wait.
// Reset: all control state clears, then an erase pass writes 0xFF to every
// cell, one cell per cycle, with in_tready low.
// Stall: while out_tready is low the result holds; one more input is
// absorbed in the input register, then in_tready drops.
// Depends on sedm_pkg, sedm_mem, sedm_ctrl and the defines header.
`include "spi_eeprom_device_model_defines.svh"

module spi_eeprom_device_model (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] mosi
  input  logic       in_tuser,   // [0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] miso
);

  logic               in_v_r;
  logic               in_op_r;
  logic [7:0]         in_mosi_r;
  logic               out_v_r;
  logic [7:0]         out_miso_r;
  logic               fire;
  logic               clr_busy;
  logic [7:0]         rd_data;
  logic [7:0]         miso;
  sedm_pkg::mem_req_t mem_req;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_busy && (!in_v_r || fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_mosi_r <= in_tdata;
    end
    if (fire) begin
      out_miso_r <= miso;
    end
  end

  sedm_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  sedm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .op      (in_op_r),
    .mosi    (in_mosi_r),
    .rd_data (rd_data),
    .miso    (miso),
    .mem_req (mem_req)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_miso_r;

  `SEDM_ASSERT_IMPL(a_no_accept_while_erasing, clr_busy, !in_tready && !in_v_r)

endmodule

@@ tb/spi_eeprom_device_model_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for spi_eeprom_device_model: SPI byte exchanges and
// chip-select releases in, predicted miso bytes compared in order at the output.
// Depends on sedm_pkg and the spi_eeprom_device_model RTL.
module spi_eeprom_device_model_tb;

  localparam logic OP_XFER    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       op;
    logic [7:0] mosi;
    logic       drain;
    logic [6:0] gap_pct;
    logic [6:0] stall_pct;
  } spi_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  spi_byte_t  stim_q[$];
  logic [7:0] miso_expected[$];
  spi_byte_t  next_byte;
  logic [7:0] want_miso;
  int         fault_count = 0;
  int         cycle_count = 0;
  int         recv_stall_pct = 0;
  int         cur_gap_pct = 0;
  int         cur_stall_pct = 0;
  logic       drain_next = 1'b0;

  logic [7:0]                  mem_image[sedm_pkg::MEM_BYTES];
  sedm_pkg::phase_t            bus_phase;
  logic [2:0]                  active_cmd;
  logic [sedm_pkg::ADDR_W-1:0] cell_ptr;
  logic                        wel;
  logic                        stored_any;

  spi_eeprom_device_model u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] eeprom_respond(input logic release_cs, input logic [7:0] mosi);
    logic [7:0] miso;
    logic [2:0] low;
    miso = 8'h00;
    low = mosi[2:0];
    if (release_cs) begin
      if (stored_any) begin
        wel = 1'b0;
        stored_any = 1'b0;
      end
      bus_phase = sedm_pkg::PH_OPCODE;
      active_cmd = sedm_pkg::INS_NONE;
      return miso;
    end
    case (bus_phase)
      sedm_pkg::PH_OPCODE: begin
        active_cmd = sedm_pkg::INS_NONE;
        bus_phase = sedm_pkg::PH_IGNORE;
        if (mosi[7:4] == 4'h0) begin
          if (low == sedm_pkg::INS_READ || (low == sedm_pkg::INS_WRITE && wel)) begin
            active_cmd = low;
            cell_ptr = {mosi[3], 8'h00};
            bus_phase = sedm_pkg::PH_ADDR;
          end else if (low == sedm_pkg::INS_WREN) begin
            wel = 1'b1;
            active_cmd = low;
          end else if (low == sedm_pkg::INS_WRDI) begin
            wel = 1'b0;
            active_cmd = low;
          end else if (low == sedm_pkg::INS_RDSR) begin
            active_cmd = low;
            bus_phase = sedm_pkg::PH_DATA;
          end
        end
      end
      sedm_pkg::PH_ADDR: begin
        cell_ptr = {cell_ptr[sedm_pkg::ADDR_W-1], mosi};
        bus_phase = sedm_pkg::PH_DATA;
      end
      sedm_pkg::PH_DATA: begin
        if (active_cmd == sedm_pkg::INS_READ) begin
          miso = mem_image[cell_ptr];
          cell_ptr = cell_ptr + sedm_pkg::ADDR_W'(1);
        end else if (active_cmd == sedm_pkg::INS_WRITE) begin
          mem_image[cell_ptr] = mosi;
          stored_any = 1'b1;
          cell_ptr = {cell_ptr[sedm_pkg::ADDR_W-1:sedm_pkg::PAGE_W],
                      cell_ptr[sedm_pkg::PAGE_W-1:0] + sedm_pkg::PAGE_W'(1)};
        end else if (active_cmd == sedm_pkg::INS_RDSR) begin
          miso = wel ? sedm_pkg::STATUS_WEL : 8'h00;
        end
      end
      default: ;
    endcase
    return miso;
  endfunction

  task automatic push_byte(input logic op, input logic [7:0] mosi);
    spi_byte_t b;
    b.op = op;
    b.mosi = mosi;
    b.drain = drain_next;
    b.gap_pct = 7'(cur_gap_pct);
    b.stall_pct = 7'(cur_stall_pct);
    stim_q.push_back(b);
    drain_next = 1'b0;
  endtask

  task automatic push_data(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      push_byte(OP_XFER, 8'($urandom));
    end
  endtask

  task automatic add_transaction();
    int unsigned pick;
    int unsigned len;
    logic [sedm_pkg::ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    if ($urandom_range(1) == 0) begin
      addr = sedm_pkg::ADDR_W'($urandom_range(sedm_pkg::MEM_BYTES - 1));
    end else begin
      addr = sedm_pkg::ADDR_W'($urandom_range(31) + sedm_pkg::MEM_BYTES - 16);
    end
    if (pick < 30) begin
      push_byte(OP_XFER, {4'h0, addr[8], sedm_pkg::INS_READ});
      push_byte(OP_XFER, addr[7:0]);
      push_data(len);
    end else if (pick < 60) begin
      if ($urandom_range(9) != 0) begin
        push_byte(OP_XFER, {4'h0, 1'($urandom), sedm_pkg::INS_WREN});
        push_byte(OP_RELEASE, 8'($urandom));
      end
      push_byte(OP_XFER, {4'h0, addr[8], sedm_pkg::INS_WRITE});
      push_byte(OP_XFER, addr[7:0]);
      push_data(len);
    end else if (pick < 70) begin
      push_byte(OP_XFER, {4'h0, 1'($urandom), sedm_pkg::INS_RDSR});
      push_data(len);
    end else if (pick < 78) begin
      push_byte(OP_XFER, {4'h0, 1'($urandom),
                          $urandom_range(1) ? sedm_pkg::INS_WREN : sedm_pkg::INS_WRDI});
      push_data(len % 3);
    end else if (pick < 90) begin
      push_byte(OP_XFER, 8'($urandom));
      push_data(len);
    end else begin
      for (int i = 0; i < len + 1; i++) begin
        push_byte(($urandom_range(3) == 0) ? OP_RELEASE : OP_XFER, 8'($urandom));
      end
    end
    push_byte(OP_RELEASE, 8'($urandom));
    if ($urandom_range(9) == 0) begin
      push_byte(OP_RELEASE, 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        miso_expected.push_back(eeprom_respond(in_tuser, in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (stim_q.size() != 0 && (!stim_q[0].drain || miso_expected.size() == 0) &&
            $urandom_range(99) >= 32'(stim_q[0].gap_pct)) begin
          next_byte = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_byte.op;
          in_tdata <= next_byte.mosi;
          recv_stall_pct <= int'(next_byte.stall_pct);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (miso_expected.size() == 0) begin
          $display("%0t: unexpected miso transaction, expected none actual %02h", $time,
                   out_tdata);
          fault_count++;
        end else begin
          want_miso = miso_expected.pop_front();
          if (out_tdata !== want_miso) begin
            $display("%0t: miso mismatch, expected %02h actual %02h", $time, want_miso,
                     out_tdata);
            fault_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < sedm_pkg::MEM_BYTES; i++) begin
      mem_image[i] = sedm_pkg::ERASED;
    end
    bus_phase = sedm_pkg::PH_OPCODE;
    active_cmd = sedm_pkg::INS_NONE;
    cell_ptr = '0;
    wel = 1'b0;
    stored_any = 1'b0;

    push_byte(OP_RELEASE, 8'hA5);
    push_byte(OP_XFER, {4'h0, 1'b0, sedm_pkg::INS_RDSR});
    push_byte(OP_XFER, 8'h00);
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, {4'h0, 1'b0, sedm_pkg::INS_WRITE});
    push_byte(OP_XFER, 8'h10);
    push_byte(OP_RELEASE, 8'hFF);
    push_byte(OP_XFER, {4'h0, 1'b1, sedm_pkg::INS_WREN});
    push_byte(OP_XFER, 8'hFF);
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, {4'h0, 1'b1, sedm_pkg::INS_RDSR});
    push_byte(OP_XFER, 8'h00);
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, {4'h0, 1'b1, sedm_pkg::INS_WRITE});
    push_byte(OP_XFER, 8'hFE);
    push_byte(OP_XFER, 8'h00);
    push_byte(OP_XFER, 8'h80);
    push_byte(OP_XFER, 8'h7F);
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, {4'h0, 1'b1, sedm_pkg::INS_READ});
    push_byte(OP_XFER, 8'hFF);
    push_byte(OP_XFER, 8'h00);
    push_byte(OP_XFER, 8'h00);
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, 8'h01);
    push_byte(OP_XFER, 8'h55);
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, {4'hF, 1'b0, sedm_pkg::INS_READ});
    push_byte(OP_RELEASE, 8'h00);
    push_byte(OP_XFER, {4'h0, 1'b0, sedm_pkg::INS_WRDI});
    push_byte(OP_RELEASE, 8'h00);

    for (int p = 0; p < 4; p++) begin
      cur_gap_pct = (p == 1) ? 88 : (p == 3) ? 11 : 0;
      cur_stall_pct = (p == 2) ? 88 : (p == 3) ? 11 : 0;
      drain_next = 1'b1;
      while (stim_q.size() < 31 + (p + 1) * 500) begin
        add_transaction();
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid) @(posedge clk);
    while (miso_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sedm_pkg.sv
hw/rtl/sedm_mem.sv
hw/rtl/sedm_ctrl.sv
hw/rtl/spi_eeprom_device_model.sv
tb/spi_eeprom_device_model_tb.sv
